/* rtl/dgds_pkg.sv */
// dgds_pkg: shared types and constants of the dot grid deviation stats block
// no dependencies; used by every module in rtl

package dgds_pkg;

    localparam int unsigned PX_W       = 20;  // Q12.8 coordinate width
    localparam int unsigned ROT_W      = 24;  // rotated offset, signed Q.8
    localparam int unsigned ERR_W      = 23;  // error to grid node, signed Q.8
    localparam int unsigned DIV_W      = 40;  // divider dividend width
    localparam int unsigned DIV_DEN_W  = 23;  // divider divisor width
    localparam int unsigned SQ_W       = 44;  // sum of squares width
    localparam int unsigned SUM_W      = 36;  // deviation sum width
    localparam int unsigned TSUM_W     = 39;  // tilt sum width, signed
    localparam int unsigned CNT_W      = 16;  // counted point width
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [5:0] NODE_DIV_BITS = 6'd24;
    localparam logic [5:0] SUM_DIV_BITS  = 6'd40;
    localparam logic [4:0] SQRT_TOP_K    = 5'd21;

    localparam logic [19:0] DEV_MAX = 20'hFFFFF;

    // register indexes of the configuration port
    localparam logic [2:0] CFG_COS   = 3'd0;
    localparam logic [2:0] CFG_SIN   = 3'd1;
    localparam logic [2:0] CFG_SX    = 3'd2;
    localparam logic [2:0] CFG_SY    = 3'd3;
    localparam logic [2:0] CFG_PITCH = 3'd4;
    localparam logic [2:0] CFG_WHW   = 3'd5;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [19:0]        start_x;
        logic [19:0]        start_y;
        logic [19:0]        grid_pitch;
        logic [19:0]        window_half_width;
    } t_cfg;

    typedef struct packed {
        logic signed [23:0] rx;
        logic signed [23:0] ry;
        logic               last;
    } t_work;

    typedef struct packed {
        logic [15:0]        point_count;
        logic signed [19:0] tilt_y;
        logic signed [19:0] tilt_x;
        logic [19:0]        max_deviation;
        logic [19:0]        average_deviation;
        logic               summary_valid;
        logic               counted;
        logic [19:0]        deviation;
        logic signed [21:0] ideal_y;
        logic signed [21:0] ideal_x;
    } t_result;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } t_front_state;

    typedef enum logic [4:0] {
        S_IDLE,
        S_XGO,
        S_XWT,
        S_XMUL,
        S_XERR,
        S_YGO,
        S_YWT,
        S_YMUL,
        S_YERR,
        S_SQX,
        S_SQY,
        S_SQADD,
        S_SQRT,
        S_ACC,
        S_AGO,
        S_AWT,
        S_TXGO,
        S_TXWT,
        S_TYGO,
        S_TYWT,
        S_DONE
    } t_back_state;

endpackage

/* rtl/dgds_front.sv */
// dgds_front: accepts dot centres, forms offsets and rotates them with one multiplier
// depends on dgds_pkg

module dgds_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [19:0]        i_point_x,
    input  logic [19:0]        i_point_y,
    input  logic               i_last,
    input  dgds_pkg::t_cfg     i_cfg,
    output logic               o_push,
    output dgds_pkg::t_work    o_work,
    input  logic               i_full
);

    dgds_pkg::t_front_state r_state, n_state;
    logic [2:0]          r_step;
    logic signed [20:0]  r_dx, r_dy;
    logic                r_last;
    logic signed [36:0]  r_prod;
    logic signed [37:0]  r_acc_x, r_acc_y;
    logic signed [15:0]  w_coef;
    logic signed [20:0]  w_var;
    logic signed [37:0]  w_rnd_x, w_rnd_y;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dgds_pkg::F_IDLE: begin
                if (i_valid) n_state = dgds_pkg::F_MUL;
            end
            dgds_pkg::F_MUL: begin
                if (r_step == 3'd4) n_state = dgds_pkg::F_PUSH;
            end
            dgds_pkg::F_PUSH: begin
                if (!i_full) n_state = dgds_pkg::F_IDLE;
            end
            default: n_state = dgds_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == dgds_pkg::F_IDLE);
        o_push  = (r_state == dgds_pkg::F_PUSH) && !i_full;
        case (r_step)
            3'd0: begin
                w_coef = i_cfg.cos_angle;
                w_var  = r_dx;
            end
            3'd1: begin
                w_coef = i_cfg.sin_angle;
                w_var  = r_dy;
            end
            3'd2: begin
                w_coef = i_cfg.sin_angle;
                w_var  = r_dx;
            end
            default: begin
                w_coef = i_cfg.cos_angle;
                w_var  = r_dy;
            end
        endcase
    end

    // round to Q.8, halves up
    assign w_rnd_x = r_acc_x + 38'sd8192;
    assign w_rnd_y = r_acc_y + 38'sd8192;

    assign o_work.rx   = w_rnd_x[37:14];
    assign o_work.ry   = w_rnd_y[37:14];
    assign o_work.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgds_pkg::F_IDLE;
            r_step  <= 3'd0;
        end else begin
            r_state <= n_state;
            if (r_state == dgds_pkg::F_IDLE) begin
                r_step <= 3'd0;
            end else if (r_state == dgds_pkg::F_MUL) begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == dgds_pkg::F_IDLE && i_valid) begin
            r_dx   <= $signed({1'b0, i_point_x}) - $signed({1'b0, i_cfg.start_x});
            r_dy   <= $signed({1'b0, i_point_y}) - $signed({1'b0, i_cfg.start_y});
            r_last <= i_last;
        end
        if (r_state == dgds_pkg::F_MUL) begin
            r_prod <= w_coef * w_var;
            case (r_step)
                3'd1: r_acc_x <= 38'(r_prod);
                3'd2: r_acc_x <= r_acc_x - 38'(r_prod);
                3'd3: r_acc_y <= 38'(r_prod);
                3'd4: r_acc_y <= r_acc_y + 38'(r_prod);
                default: ;
            endcase
        end
    end

endmodule

/* rtl/dgds_queue.sv */
// dgds_queue: short queue of rotated points between front and back
// depends on dgds_pkg

module dgds_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dgds_pkg::t_work i_work,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output dgds_pkg::t_work o_work
);

    localparam int unsigned DEPTH = dgds_pkg::QUEUE_DEPTH;
    localparam int unsigned AW    = $clog2(DEPTH);

    dgds_pkg::t_work r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_work  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_work;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

/* rtl/dgds_div.sv */
// dgds_div: shared restoring divider, one quotient bit per cycle
// depends on dgds_pkg

module dgds_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [5:0]  i_nbits,
    input  logic [22:0] i_den,
    output logic        o_done,
    output logic [39:0] o_quo
);

    logic [39:0] r_num, r_quo;
    logic [22:0] r_rem, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [23:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_num[39]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign o_done  = r_done;
    assign o_quo   = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // align the dividend to the top so only i_nbits steps are needed
            r_num <= i_num << (6'(dgds_pkg::DIV_W) - i_nbits);
            r_rem <= '0;
            r_quo <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_quo <= {r_quo[38:0], w_ge};
            r_rem <= w_ge ? 23'(w_trial - {1'b0, r_den}) : w_trial[22:0];
        end
    end

endmodule

/* rtl/dgds_back.sv */
// dgds_back: grid snap, deviation square root, accumulation and summary
// depends on dgds_pkg and dgds_div

module dgds_back #(
    parameter int unsigned MAX_POINTS = 65535
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    output logic              o_pop,
    input  dgds_pkg::t_work   i_work,
    input  dgds_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output dgds_pkg::t_result o_result
);

    dgds_pkg::t_back_state r_state, n_state;

    dgds_pkg::t_work    r_work;
    logic signed [23:0] r_n;
    logic signed [49:0] r_prod;
    logic signed [22:0] r_ex, r_ey;
    logic signed [21:0] r_ix, r_iy;
    logic [43:0]        r_sq, r_s, r_r;
    logic [4:0]         r_k;
    logic [19:0]        r_dev;
    logic               r_counted;
    logic [19:0]        r_avg;
    logic signed [19:0] r_tx, r_ty;
    logic [35:0]        r_dsum;
    logic signed [38:0] r_tsum_x, r_tsum_y;
    logic [19:0]        r_largest;
    logic [15:0]        r_cntp;
    logic               r_out_valid;
    dgds_pkg::t_result  r_result;

    logic               w_div_start, w_div_done;
    logic [39:0]        w_div_num, w_div_quo;
    logic [5:0]         w_div_nbits;
    logic [22:0]        w_div_den;
    logic signed [24:0] w_ma, w_mb;
    logic [19:0]        w_pitch;
    logic               w_use_y;
    logic signed [23:0] w_sel_rx;
    logic [23:0]        w_abs_sel, w_abs_rx;
    logic signed [25:0] w_prod26, w_err, w_node;
    logic [19:0]        w_sel_start;
    logic [43:0]        w_bit, w_try, w_root;
    logic [19:0]        w_dev;
    logic               w_cnt, w_out_free;
    logic               w_tilt_neg;
    logic [38:0]        w_abs_tx, w_abs_ty;
    logic signed [19:0] w_tilt;

    dgds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_nbits (w_div_nbits),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // zero pitch acts as one lsb
    assign w_pitch = (i_cfg.grid_pitch == '0) ? 20'd1 : i_cfg.grid_pitch;

    assign w_use_y     = (r_state == dgds_pkg::S_YGO) || (r_state == dgds_pkg::S_YWT)
                      || (r_state == dgds_pkg::S_YERR);
    assign w_sel_rx    = w_use_y ? r_work.ry : r_work.rx;
    assign w_sel_start = w_use_y ? i_cfg.start_y : i_cfg.start_x;
    assign w_abs_sel   = w_sel_rx[23] ? 24'(-w_sel_rx) : 24'(w_sel_rx);
    assign w_abs_rx    = r_work.rx[23] ? 24'(-r_work.rx) : 24'(r_work.rx);
    assign w_abs_tx    = r_tsum_x[38] ? 39'(-r_tsum_x) : 39'(r_tsum_x);
    assign w_abs_ty    = r_tsum_y[38] ? 39'(-r_tsum_y) : 39'(r_tsum_y);

    // error and node of the axis being worked on
    assign w_prod26 = r_prod[25:0];
    assign w_err    = 26'(w_sel_rx) - w_prod26;
    assign w_node   = $signed({6'b0, w_sel_start}) + w_prod26;

    // square root step
    assign w_bit  = 44'd1 << {r_k, 1'b0};
    assign w_try  = r_r + w_bit;
    assign w_root = (r_s > r_r) ? r_r + 44'd1 : r_r;
    assign w_dev  = (w_root > 44'(dgds_pkg::DEV_MAX)) ? dgds_pkg::DEV_MAX : w_root[19:0];

    // a point on the window edge is not counted
    assign w_cnt = (w_abs_rx < {4'b0, i_cfg.window_half_width})
                && (r_cntp < 16'(MAX_POINTS));

    assign w_out_free = !r_out_valid || i_ready;

    // signed mean saturated to 20 bits
    assign w_tilt_neg = (r_state == dgds_pkg::S_TYWT) ? r_tsum_y[38] : r_tsum_x[38];
    always_comb begin
        if (!w_tilt_neg) begin
            w_tilt = (w_div_quo > 40'd524287) ? 20'sd524287 : $signed(w_div_quo[19:0]);
        end else begin
            w_tilt = (w_div_quo > 40'd524288) ? -20'sd524288 : $signed(20'(-w_div_quo));
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dgds_pkg::S_IDLE:  if (!i_empty) n_state = dgds_pkg::S_XGO;
            dgds_pkg::S_XGO:   n_state = dgds_pkg::S_XWT;
            dgds_pkg::S_XWT:   if (w_div_done) n_state = dgds_pkg::S_XMUL;
            dgds_pkg::S_XMUL:  n_state = dgds_pkg::S_XERR;
            dgds_pkg::S_XERR:  n_state = dgds_pkg::S_YGO;
            dgds_pkg::S_YGO:   n_state = dgds_pkg::S_YWT;
            dgds_pkg::S_YWT:   if (w_div_done) n_state = dgds_pkg::S_YMUL;
            dgds_pkg::S_YMUL:  n_state = dgds_pkg::S_YERR;
            dgds_pkg::S_YERR:  n_state = dgds_pkg::S_SQX;
            dgds_pkg::S_SQX:   n_state = dgds_pkg::S_SQY;
            dgds_pkg::S_SQY:   n_state = dgds_pkg::S_SQADD;
            dgds_pkg::S_SQADD: n_state = dgds_pkg::S_SQRT;
            dgds_pkg::S_SQRT:  if (r_k == '0) n_state = dgds_pkg::S_ACC;
            dgds_pkg::S_ACC: begin
                if (r_work.last && (r_cntp != '0 || w_cnt)) n_state = dgds_pkg::S_AGO;
                else n_state = dgds_pkg::S_DONE;
            end
            dgds_pkg::S_AGO:   n_state = dgds_pkg::S_AWT;
            dgds_pkg::S_AWT:   if (w_div_done) n_state = dgds_pkg::S_TXGO;
            dgds_pkg::S_TXGO:  n_state = dgds_pkg::S_TXWT;
            dgds_pkg::S_TXWT:  if (w_div_done) n_state = dgds_pkg::S_TYGO;
            dgds_pkg::S_TYGO:  n_state = dgds_pkg::S_TYWT;
            dgds_pkg::S_TYWT:  if (w_div_done) n_state = dgds_pkg::S_DONE;
            dgds_pkg::S_DONE:  if (w_out_free) n_state = dgds_pkg::S_IDLE;
            default:           n_state = dgds_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == dgds_pkg::S_IDLE) && !i_empty;
        o_valid     = r_out_valid;
        o_result    = r_result;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = 23'd1;
        w_div_nbits = dgds_pkg::SUM_DIV_BITS;
        w_ma        = '0;
        w_mb        = $signed({5'b0, w_pitch});
        case (r_state)
            dgds_pkg::S_XGO, dgds_pkg::S_YGO: begin
                w_div_start = 1'b1;
                w_div_num   = 40'({w_abs_sel, 1'b0}) + 40'(w_pitch);
                w_div_den   = 23'({w_pitch, 1'b0});
                w_div_nbits = dgds_pkg::NODE_DIV_BITS;
            end
            dgds_pkg::S_AGO: begin
                w_div_start = 1'b1;
                w_div_num   = 40'({r_dsum, 1'b0}) + 40'(r_cntp);
                w_div_den   = 23'({r_cntp, 1'b0});
            end
            dgds_pkg::S_TXGO: begin
                w_div_start = 1'b1;
                w_div_num   = {w_abs_tx, 1'b0} + 40'(r_cntp);
                w_div_den   = 23'({r_cntp, 1'b0});
            end
            dgds_pkg::S_TYGO: begin
                w_div_start = 1'b1;
                w_div_num   = {w_abs_ty, 1'b0} + 40'(r_cntp);
                w_div_den   = 23'({r_cntp, 1'b0});
            end
            dgds_pkg::S_XMUL, dgds_pkg::S_YMUL: begin
                w_ma = 25'(r_n);
            end
            dgds_pkg::S_SQX: begin
                w_ma = 25'(r_ex);
                w_mb = 25'(r_ex);
            end
            dgds_pkg::S_SQY: begin
                w_ma = 25'(r_ey);
                w_mb = 25'(r_ey);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dgds_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_dsum      <= '0;
            r_tsum_x    <= '0;
            r_tsum_y    <= '0;
            r_largest   <= '0;
            r_cntp      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == dgds_pkg::S_DONE && w_out_free) r_out_valid <= 1'b1;
            else if (i_ready)                              r_out_valid <= 1'b0;
            if (r_state == dgds_pkg::S_ACC && w_cnt) begin
                r_dsum   <= r_dsum + 36'(w_dev);
                r_tsum_x <= r_tsum_x + 39'(r_ex);
                r_tsum_y <= r_tsum_y + 39'(r_ey);
                r_cntp   <= r_cntp + 16'd1;
                if (w_dev > r_largest) r_largest <= w_dev;
            end
            if (r_state == dgds_pkg::S_DONE && w_out_free) begin
                if (r_work.last) begin
                    r_dsum    <= '0;
                    r_tsum_x  <= '0;
                    r_tsum_y  <= '0;
                    r_largest <= '0;
                    r_cntp    <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
        case (r_state)
            dgds_pkg::S_IDLE: begin
                r_work <= i_work;
            end
            dgds_pkg::S_XWT, dgds_pkg::S_YWT: begin
                if (w_div_done) begin
                    r_n <= w_sel_rx[23] ? -$signed(w_div_quo[23:0]) : $signed(w_div_quo[23:0]);
                end
            end
            dgds_pkg::S_XERR, dgds_pkg::S_YERR: begin
                if (w_use_y) r_ey <= w_err[22:0];
                else         r_ex <= w_err[22:0];
                if (w_node > 26'sd2097151) begin
                    if (w_use_y) r_iy <= 22'sd2097151;
                    else         r_ix <= 22'sd2097151;
                end else if (w_node < -26'sd2097152) begin
                    if (w_use_y) r_iy <= -22'sd2097152;
                    else         r_ix <= -22'sd2097152;
                end else begin
                    if (w_use_y) r_iy <= w_node[21:0];
                    else         r_ix <= w_node[21:0];
                end
            end
            dgds_pkg::S_SQY: begin
                r_sq <= r_prod[43:0];
            end
            dgds_pkg::S_SQADD: begin
                r_s <= r_sq + r_prod[43:0];
                r_r <= '0;
                r_k <= dgds_pkg::SQRT_TOP_K;
            end
            dgds_pkg::S_SQRT: begin
                if (r_s >= w_try) begin
                    r_s <= r_s - w_try;
                    r_r <= (r_r >> 1) + w_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_k <= r_k - 5'd1;
            end
            dgds_pkg::S_ACC: begin
                r_dev     <= w_dev;
                r_counted <= w_cnt;
                r_avg     <= '0;
                r_tx      <= '0;
                r_ty      <= '0;
            end
            dgds_pkg::S_AWT: begin
                if (w_div_done) begin
                    r_avg <= (w_div_quo > 40'(dgds_pkg::DEV_MAX)) ? dgds_pkg::DEV_MAX
                                                                  : w_div_quo[19:0];
                end
            end
            dgds_pkg::S_TXWT: if (w_div_done) r_tx <= w_tilt;
            dgds_pkg::S_TYWT: if (w_div_done) r_ty <= w_tilt;
            dgds_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_result.ideal_x           <= r_ix;
                    r_result.ideal_y           <= r_iy;
                    r_result.deviation         <= r_dev;
                    r_result.counted           <= r_counted;
                    r_result.summary_valid     <= r_work.last;
                    r_result.average_deviation <= r_avg;
                    r_result.max_deviation     <= r_work.last ? r_largest : '0;
                    r_result.tilt_x            <= r_tx;
                    r_result.tilt_y            <= r_ty;
                    r_result.point_count       <= r_work.last ? r_cntp : '0;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cntp <= 16'(MAX_POINTS))
        else $error("counted points beyond limit");
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == dgds_pkg::S_XWT || r_state == dgds_pkg::S_YWT
                     || r_state == dgds_pkg::S_AWT || r_state == dgds_pkg::S_TXWT
                     || r_state == dgds_pkg::S_TYWT))
        else $error("divider finished outside a wait state");
    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dgds_pkg::S_DONE && w_out_free) |=> r_out_valid)
        else $error("result not presented after completion");
`endif

endmodule

/* rtl/dot_grid_deviation_stats_core.sv */
// dot_grid_deviation_stats_core: top level with configuration registers and port packing
// depends on dgds_pkg, dgds_front, dgds_queue, dgds_back

// Takes dot centres (Q12.8) one beat at a time, rotates each about the start point by
// the configured cosine and sine, snaps it to the nearest node of the square grid and
// returns the node, the Euclidean deviation and whether the point fell inside the
// column window; the beat marked tlast also carries the averages, tilt, maximum and
// count of the set, and the accumulators clear after it. In the back end a point takes
// two 24-step node divisions, four multiplies, a 22-step square root and bookkeeping
// states, all on one shared divider and one multiplier; the last point of a set adds
// three 40-step divisions for the means. The front takes one point at a time and a
// two-entry queue lets it run ahead while the back end works; a result waiting on
// m_axis_tready holds the back end only once the next result is finished and the
// output register is still occupied. Configuration is written through i_cfg_wr_en,
// i_cfg_index and i_cfg_data; the user must do so only while idle; the block does not enforce it.

module dot_grid_deviation_stats_core #(
    parameter int unsigned MAX_POINTS = 65535
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write port
    input  logic         i_cfg_wr_en,
    input  logic [2:0]   i_cfg_index,
    input  logic [19:0]  i_cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // point_x[19:0], point_y[39:20]
    input  logic         s_axis_tlast,   // last_point
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [167:0] m_axis_tdata,   // ideal_x, ideal_y, deviation, counted,
                                         // average_deviation, max_deviation,
                                         // tilt_x, tilt_y, point_count, zero pad
    output logic         m_axis_tuser    // summary_valid
);

    dgds_pkg::t_cfg    r_cfg;
    dgds_pkg::t_work   w_front_work, w_queue_work;
    dgds_pkg::t_result w_result;
    logic              w_push, w_full, w_pop, w_empty;

    // configuration registers, reset to the identity rotation and default grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_angle         <= 16'sd16384;
            r_cfg.sin_angle         <= '0;
            r_cfg.start_x           <= '0;
            r_cfg.start_y           <= '0;
            r_cfg.grid_pitch        <= 20'd25600;
            r_cfg.window_half_width <= 20'd12800;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                dgds_pkg::CFG_COS:   r_cfg.cos_angle         <= i_cfg_data[15:0];
                dgds_pkg::CFG_SIN:   r_cfg.sin_angle         <= i_cfg_data[15:0];
                dgds_pkg::CFG_SX:    r_cfg.start_x           <= i_cfg_data;
                dgds_pkg::CFG_SY:    r_cfg.start_y           <= i_cfg_data;
                dgds_pkg::CFG_PITCH: r_cfg.grid_pitch        <= i_cfg_data;
                dgds_pkg::CFG_WHW:   r_cfg.window_half_width <= i_cfg_data;
                default: ;  // unused indexes are dropped
            endcase
        end
    end

    // front: accept and rotate
    dgds_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_point_x (s_axis_tdata[19:0]),
        .i_point_y (s_axis_tdata[39:20]),
        .i_last    (s_axis_tlast),
        .i_cfg     (r_cfg),
        .o_push    (w_push),
        .o_work    (w_front_work),
        .i_full    (w_full)
    );

    // decouples rotation from the long snap and root sequence
    dgds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_front_work),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_work  (w_queue_work)
    );

    // back: snap, deviation, stats, output register
    dgds_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .i_work   (w_queue_work),
        .i_cfg    (r_cfg),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    assign m_axis_tdata = {7'b0,
                           w_result.point_count,
                           w_result.tilt_y,
                           w_result.tilt_x,
                           w_result.max_deviation,
                           w_result.average_deviation,
                           w_result.counted,
                           w_result.deviation,
                           w_result.ideal_y,
                           w_result.ideal_x};
    assign m_axis_tuser = w_result.summary_valid;

endmodule
